### hw/rtl/front_panel_response_deframer_assert.svh
// Assertion macros shared by the deframer modules.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef FRONT_PANEL_RESPONSE_DEFRAMER_ASSERT_SVH
`define FRONT_PANEL_RESPONSE_DEFRAMER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define FPRD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer check failed");

// Next-cycle implication, off during reset.
`define FPRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

### hw/rtl/fprd_pkg.sv
// ----------------------------------------------------------------------------
// fprd_pkg
// Shared types, event id ranges and frame length lookup for the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package fprd_pkg;

  localparam int FPRD_QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_KEY     = 2'd0,
    KIND_ANSWER  = 2'd1,
    KIND_UNKNOWN = 2'd2
  } kind_t;

  // Event id ranges
  localparam logic [7:0] ID_KEY_FIRST  = 8'he0;
  localparam logic [7:0] ID_KEY_LAST   = 8'he2;
  localparam logic [7:0] ID_WAKE_FIRST = 8'he3;
  localparam logic [7:0] ID_WAKE_LAST  = 8'he8;
  localparam logic [7:0] ID_DATE_FIRST = 8'he9;
  localparam logic [7:0] ID_DATE_LAST  = 8'heb;
  localparam logic [7:0] ID_MISC_FIRST = 8'hec;
  localparam logic [7:0] ID_MISC_LAST  = 8'hef;

  // Offset of the last byte within a frame (frame length minus one)
  localparam logic [3:0] LAST_OFS_SHORT = 4'd1;
  localparam logic [3:0] LAST_OFS_DATE  = 4'd5;
  localparam logic [3:0] LAST_OFS_WAKE  = 4'd11;
  localparam logic [3:0] LAST_OFS_NONE  = 4'd0;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] event_id;
    logic       frame_end;
  } result_t;

  // Last offset of the frame an id opens; LAST_OFS_NONE for unknown ids.
  function automatic logic [3:0] frame_last(input logic [7:0] id);
    logic [3:0] ofs;
    ofs = LAST_OFS_NONE;
    if (id >= ID_KEY_FIRST && id <= ID_KEY_LAST) ofs = LAST_OFS_SHORT;
    if (id >= ID_WAKE_FIRST && id <= ID_WAKE_LAST) ofs = LAST_OFS_WAKE;
    if (id >= ID_DATE_FIRST && id <= ID_DATE_LAST) ofs = LAST_OFS_DATE;
    if (id >= ID_MISC_FIRST && id <= ID_MISC_LAST) ofs = LAST_OFS_SHORT;
    return ofs;
  endfunction

  function automatic logic is_key_id(input logic [7:0] id);
    return (id >= ID_KEY_FIRST) && (id <= ID_KEY_LAST);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/front_panel_response_deframer.sv
// ----------------------------------------------------------------------------
// front_panel_response_deframer
// Splits the byte stream from a front-panel controller into key event bytes,
// answer payload bytes and dropped unknown ids.
//
// Input channel: in_valid / in_stall with rx_byte, one byte per transfer.
// Output channel: out_valid / out_stall with kind, data, event_id, frame_end.
// Each accepted byte gives zero or one result: key frames pass both bytes,
// answer frames pass odd-offset payload bytes (frame_end marks the ack), and
// an unknown id gives one kind-2 result and the next byte is read as an id.
// Results are registered in the queue and leave it in order of arrival.
// Throughput: one byte per cycle while the result queue has room; the queue
// holds QUEUE_DEPTH results, so the input stalls only after the receiver has
// held out_stall long enough to fill it.
// Reset: clears the frame tracking (waiting for an id) and empties the
// queue; out_valid is low after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module front_panel_response_deframer
  import fprd_pkg::*;
#(
  parameter int QUEUE_DEPTH = FPRD_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      kind,
  output logic [7:0]      data,
  output logic [7:0]      event_id,
  output logic            frame_end
);

  logic    q_full;
  logic    push;
  result_t push_data;
  result_t head;

  fprd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  fprd_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign kind      = head.kind;
  assign data      = head.data;
  assign event_id  = head.event_id;
  assign frame_end = head.frame_end;

endmodule

`default_nettype wire

### hw/rtl/fprd_front.sv
// ----------------------------------------------------------------------------
// fprd_front
// Accepts received bytes, tracks the frame position and classifies each byte
// into a result that is pushed into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fprd_front
  import fprd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       q_full,
  output logic            push,
  output result_t         push_data
);

  `include "front_panel_response_deframer_assert.svh"

  typedef enum logic [1:0] {
    ST_ID   = 2'b01,
    ST_BODY = 2'b10
  } state_t;

  state_t     state, state_next;
  logic [7:0] frame_id, frame_id_next;
  logic [3:0] byte_pos, byte_pos_next;

  logic       accept;
  logic [3:0] id_last_ofs;
  logic [3:0] cur_last_ofs;
  logic       last_byte;

  assign in_stall     = q_full;
  assign accept       = in_valid && !q_full;
  assign id_last_ofs  = frame_last(rx_byte);
  assign cur_last_ofs = frame_last(frame_id);
  // Positions at or past the last offset close the frame
  assign last_byte    = byte_pos >= cur_last_ofs;

  always_comb begin
    state_next    = state;
    frame_id_next = frame_id;
    byte_pos_next = byte_pos;
    push          = 1'b0;
    push_data     = '{kind: KIND_KEY, data: rx_byte, event_id: frame_id, frame_end: 1'b0};
    case (state)
      ST_ID: begin
        push_data.event_id = rx_byte;
        if (accept) begin
          if (id_last_ofs == LAST_OFS_NONE) begin
            // drop unknown id, stay waiting for an id
            push           = 1'b1;
            push_data.kind = KIND_UNKNOWN;
          end else begin
            state_next    = ST_BODY;
            frame_id_next = rx_byte;
            byte_pos_next = 4'd1;
            push          = is_key_id(rx_byte);
          end
        end
      end
      ST_BODY: begin
        push_data.frame_end = last_byte;
        if (!is_key_id(frame_id)) begin
          push_data.kind = KIND_ANSWER;
        end
        if (accept) begin
          // answers drop tag bytes at even offsets
          push = is_key_id(frame_id) || byte_pos[0] || last_byte;
          if (last_byte) begin
            state_next    = ST_ID;
            byte_pos_next = 4'd0;
          end else begin
            byte_pos_next = byte_pos + 4'd1;
          end
        end
      end
      default: begin
        state_next    = ST_ID;
        byte_pos_next = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_ID;
      frame_id <= 8'd0;
      byte_pos <= 4'd0;
    end else begin
      state    <= state_next;
      frame_id <= frame_id_next;
      byte_pos <= byte_pos_next;
    end
  end

  `FPRD_ASSERT_NOW(a_body_pos_nonzero, state == ST_BODY, byte_pos != 4'd0)
  `FPRD_ASSERT_NOW(a_body_id_known, state == ST_BODY, cur_last_ofs != LAST_OFS_NONE)
  `FPRD_ASSERT_NOW(a_unknown_no_end, push && push_data.kind == KIND_UNKNOWN,
                   !push_data.frame_end && state == ST_ID)

endmodule

`default_nettype wire

### hw/rtl/fprd_queue.sv
// ----------------------------------------------------------------------------
// fprd_queue
// Small result queue between the classifier and the output channel; its head
// entry drives the output payload.
// ----------------------------------------------------------------------------
`default_nettype none

module fprd_queue
  import fprd_pkg::*;
#(
  parameter int Depth = FPRD_QUEUE_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_stall,
  output result_t      head
);

  `include "front_panel_response_deframer_assert.svh"

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  result_t        entries [Depth];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           pop;

  assign full      = count == CW'(Depth);
  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `FPRD_ASSERT_NOW(a_no_push_full, full, !push)
  `FPRD_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(Depth))
  `FPRD_ASSERT_NEXT(a_pop_drains, pop && !push, count == $past(count) - 1'b1)

endmodule

`default_nettype wire

### dv/front_panel_response_deframer_checker.sv
// ----------------------------------------------------------------------------
// front_panel_response_deframer_checker
// Watches both channels of the deframer. Every input transfer goes through a
// frame tracker of its own, and any result that byte gives is queued. Every
// output transfer is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module front_panel_response_deframer_checker
  import fprd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] kind,
  input  logic [7:0] data,
  input  logic [7:0] event_id,
  input  logic       frame_end,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Frame tracker state
  logic [7:0] open_id;
  logic [3:0] next_ofs;
  logic       frame_open;

  result_t queued_results[$];

  // Offset of the closing byte of the frame an id opens; 0 for unknown ids.
  function automatic logic [3:0] closing_offset(input logic [7:0] id);
    logic [3:0] ofs;
    ofs = 4'd0;
    if (id >= 8'he0 && id <= 8'he2) ofs = 4'd1;
    else if (id >= 8'he3 && id <= 8'he8) ofs = 4'd11;
    else if (id >= 8'he9 && id <= 8'heb) ofs = 4'd5;
    else if (id >= 8'hec && id <= 8'hef) ofs = 4'd1;
    return ofs;
  endfunction

  function automatic logic key_frame(input logic [7:0] id);
    return id >= 8'he0 && id <= 8'he2;
  endfunction

  task automatic queue_result(input kind_t k, input logic [7:0] d,
                              input logic [7:0] id, input logic fin);
    result_t r;
    r.kind      = k;
    r.data      = d;
    r.event_id  = id;
    r.frame_end = fin;
    queued_results.push_back(r);
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [3:0] close_ofs;
    logic       closing;
    if (!frame_open) begin
      close_ofs = closing_offset(b);
      if (close_ofs == 4'd0) begin
        // unknown id: report and keep waiting for an id
        queue_result(KIND_UNKNOWN, b, b, 1'b0);
      end else begin
        open_id    = b;
        next_ofs   = 4'd1;
        frame_open = 1'b1;
        if (key_frame(b)) queue_result(KIND_KEY, b, b, 1'b0);
      end
    end else begin
      close_ofs = closing_offset(open_id);
      closing   = next_ofs >= close_ofs;
      if (key_frame(open_id)) queue_result(KIND_KEY, b, open_id, closing);
      else if (next_ofs[0] || closing) queue_result(KIND_ANSWER, b, open_id, closing);
      if (closing) begin
        frame_open = 1'b0;
        next_ofs   = 4'd0;
      end else begin
        next_ofs = next_ofs + 4'd1;
      end
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      open_id    = 8'd0;
      next_ofs   = 4'd0;
      frame_open = 1'b0;
      queued_results.delete();
    end else begin
      // the result at this edge always stems from an earlier byte
      if (out_valid && !out_stall) begin
        if (queued_results.size() == 0) begin
          $error("unexpected result: kind %0d data %0h event_id %0h frame_end %0b",
                 kind, data, event_id, frame_end);
          errors = errors + 1;
        end else begin
          want = queued_results.pop_front();
          if (kind !== want.kind) begin
            $error("kind mismatch: expected %0d, got %0d", want.kind, kind);
            errors = errors + 1;
          end
          if (data !== want.data) begin
            $error("data mismatch: expected %0h, got %0h", want.data, data);
            errors = errors + 1;
          end
          if (event_id !== want.event_id) begin
            $error("event_id mismatch: expected %0h, got %0h", want.event_id, event_id);
            errors = errors + 1;
          end
          if (frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %0b, got %0b", want.frame_end, frame_end);
            errors = errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) deframe_byte(rx_byte);
    end
    pending = queued_results.size();
  end

endmodule

### dv/front_panel_response_deframer_tb.sv
// ----------------------------------------------------------------------------
// front_panel_response_deframer_tb
// Feeds the deframer directed frames and then a long random byte stream,
// mostly whole frames with random content, plus noise bytes and cut frames.
// Both channels idle at random; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module front_panel_response_deframer_tb
  import fprd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1800;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] kind;
  logic [7:0] data;
  logic [7:0] event_id;
  logic       frame_end;
  int         errors;
  int         pending;

  int bytes_sent;
  bit in_burst;
  bit out_burst;

  front_panel_response_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .data      (data),
    .event_id  (event_id),
    .frame_end (frame_end)
  );

  front_panel_response_deframer_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .data      (data),
    .event_id  (event_id),
    .frame_end (frame_end),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Frame length in bytes for a known id, 1 for anything else.
  function automatic int frame_bytes(input logic [7:0] id);
    if (id >= ID_KEY_FIRST && id <= ID_KEY_LAST) return 2;
    if (id >= ID_WAKE_FIRST && id <= ID_WAKE_LAST) return 12;
    if (id >= ID_DATE_FIRST && id <= ID_DATE_LAST) return 6;
    if (id >= ID_MISC_FIRST && id <= ID_MISC_LAST) return 2;
    return 1;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 19);
    // keep valid high between back-to-back transfers
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Payload bytes are random, with some id-like values mixed in.
  function automatic logic [7:0] payload_byte();
    if ($urandom_range(0, 3) == 0) return 8'he0 + 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  // Send a frame; a nonzero cut ends it early after a random number of bytes.
  task automatic send_frame(input logic [7:0] id, input bit cut);
    int n;
    n = frame_bytes(id);
    if (cut && n > 1) n = $urandom_range(1, n - 1);
    send_byte(id);
    for (int i = 1; i < n; i++) send_byte(payload_byte());
  endtask

  // Receiver: draw a stall before each result, then take it.
  initial begin
    int hold;
    out_stall = 1'b0;
    out_burst = 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      hold = out_burst ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int sel;
    rst        = 1'b1;
    in_valid   = 1'b0;
    rx_byte    = 8'd0;
    bytes_sent = 0;
    in_burst   = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unknown ids at both ends of the byte range
    send_byte(8'h00);
    send_byte(8'hff);
    // key frames with extreme payloads
    send_byte(ID_KEY_LAST);
    send_byte(8'h00);
    send_byte(ID_KEY_FIRST);
    send_byte(8'hff);
    // short answer
    send_byte(ID_MISC_LAST);
    send_byte(8'h55);
    // date answer: tags dropped, last byte is the ack
    send_byte(ID_DATE_FIRST);
    for (int i = 1; i < 6; i++) send_byte(i[0] ? 8'hff : 8'h00);
    // wakeup-time answer
    send_frame(ID_WAKE_LAST, 1'b0);

    while (bytes_sent < RANDOM_BYTES) begin
      sel = $urandom_range(0, 9);
      if (sel < 8) send_frame(8'he0 + 8'($urandom_range(0, 15)), 1'b0);
      else if (sel == 8) send_byte(8'($urandom_range(0, 255)));
      else send_frame(8'he0 + 8'($urandom_range(0, 15)), 1'b1);
    end
    in_valid <= 1'b0;
    // let the checker count the last transfer before polling
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[front_panel_response_deframer] OK");
    end else begin
      $display("[front_panel_response_deframer] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[front_panel_response_deframer] ERROR");
    $finish;
  end

endmodule
